FILE: hw/rtl/tlvc_pkg.sv
// ----------------------------------------------------------------------------
// tlvc_pkg: shared types and constants of the tank level valve controller
// Field widths, command, mode, reason and register codes, reset values and
// the flag bundle that travels with each beat through the pipeline.
// ----------------------------------------------------------------------------
package tlvc_pkg;

  localparam int WINDOW_DEFAULT = 64;

  localparam int CMD_W       = 2;
  localparam int MODE_W      = 2;
  localparam int REASON_W    = 2;
  localparam int SAMPLE_W    = 10;
  localparam int LITERS_W    = 16;
  localparam int COEF_W      = 16;
  localparam int PERCENT_W   = 7;
  localparam int TIMEOUT_W   = 8;
  localparam int DEBOUNCE_W  = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CMD_W-1:0] CMD_MS_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEC_TICK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET_MODE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_CISTERN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAINS   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HYST    = 2'd2;

  localparam logic [REASON_W-1:0] REASON_MANUAL = 2'd0;
  localparam logic [REASON_W-1:0] REASON_FULL   = 2'd1;
  localparam logic [REASON_W-1:0] REASON_EMPTY  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_FULL_LITERS       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LITERS_PER_COUNT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERCENT_PER_COUNT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_LIMIT_LITERS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_LIMIT_LITERS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SETTINGS_TIMEOUT  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_MS       = 3'd6;

  localparam logic [LITERS_W-1:0]   FULL_LITERS_RST       = 16'd6300;
  localparam logic [COEF_W-1:0]     LITERS_PER_COUNT_RST  = 16'd2114;
  localparam logic [COEF_W-1:0]     PERCENT_PER_COUNT_RST = 16'd8589;
  localparam logic [LITERS_W-1:0]   LOW_LIMIT_RST         = 16'd500;
  localparam logic [LITERS_W-1:0]   HIGH_LIMIT_RST        = 16'd1000;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST           = 8'd10;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST          = 10'd200;

  localparam logic [DEBOUNCE_W-1:0] SINCE_PRESS_MAX = '1;
  localparam logic [PERCENT_W-1:0]  PERCENT_MAX     = 7'd100;

  typedef struct packed {
    logic [LITERS_W-1:0]   full_liters;
    logic [COEF_W-1:0]     liters_per_count;
    logic [COEF_W-1:0]     percent_per_count;
    logic [LITERS_W-1:0]   low_limit_liters;
    logic [LITERS_W-1:0]   high_limit_liters;
    logic [TIMEOUT_W-1:0]  settings_timeout_s;
    logic [DEBOUNCE_W-1:0] debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              settings;
    logic              tick;
    logic              decide;
  } beat_flags_t;

endpackage

FILE: hw/rtl/tlvc_ctrl.sv
// ----------------------------------------------------------------------------
// tlvc_ctrl: input register, button and mode control, sample window
// Registers the incoming beat, then updates debounce, settings countdown,
// mode, the sample ring and the window sum, and hands the beat on.
// ----------------------------------------------------------------------------
module tlvc_ctrl import tlvc_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT,
  localparam int POS_W = $clog2(WINDOW),
  localparam int SUM_W = SAMPLE_W + POS_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [CMD_W-1:0]    command,
  input  logic                button_low,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [MODE_W-1:0]   new_mode,
  input  cfg_t                cfg,
  input  logic                down_ready,
  output logic                s2_valid,
  output beat_flags_t         s2_flags,
  output logic [SUM_W-1:0]    s2_sum
);

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

  logic                  v1;
  logic [CMD_W-1:0]      cmd1;
  logic                  btn1;
  logic [SAMPLE_W-1:0]   smp1;
  logic [MODE_W-1:0]     nmode1;

  logic [MODE_W-1:0]     mode, mode_next;
  logic                  in_settings, in_settings_next;
  logic [TIMEOUT_W-1:0]  countdown, countdown_next;
  logic [DEBOUNCE_W-1:0] since_press, since_press_next;
  logic [POS_W-1:0]      pos, pos_next;
  logic                  full, full_next;
  logic [SUM_W-1:0]      sum, sum_next;

  logic [SAMPLE_W-1:0]   ring [WINDOW];
  logic [SAMPLE_W-1:0]   rd_data;
  logic                  rd_valid;

  logic                  ready2, adv, ring_we, tick, press;
  logic [DEBOUNCE_W-1:0] sp_inc;
  logic [SAMPLE_W-1:0]   oldest;

  assign ready2     = !s2_valid || down_ready;
  assign adv        = v1 && ready2;
  assign item_stall = v1 && !ready2;
  assign tick       = (cmd1 == CMD_SEC_TICK);
  assign ring_we    = adv && tick;
  assign oldest     = rd_valid ? rd_data : '0;
  assign sp_inc     = (since_press == SINCE_PRESS_MAX) ? since_press : since_press + 1'b1;
  assign press      = btn1 && ((sp_inc > cfg.debounce_ms) || (sp_inc == SINCE_PRESS_MAX));

  always_comb begin
    mode_next        = mode;
    in_settings_next = in_settings;
    countdown_next   = countdown;
    since_press_next = since_press;
    pos_next         = pos;
    full_next        = full;
    sum_next         = sum;
    if (adv) begin
      case (cmd1)
        CMD_MS_TICK: begin
          since_press_next = sp_inc;
          if (press) begin
            since_press_next = '0;
            countdown_next   = cfg.settings_timeout_s;
            if (!in_settings) begin
              in_settings_next = 1'b1;
            end else begin
              mode_next = (mode == MODE_CISTERN) ? MODE_HYST : mode - 1'b1;
            end
          end
        end
        CMD_SEC_TICK: begin
          sum_next  = sum - SUM_W'(oldest) + SUM_W'(smp1);
          pos_next  = (pos == POS_LAST) ? '0 : pos + 1'b1;
          full_next = full || (pos == POS_LAST);
          if (in_settings) begin
            if (countdown <= 8'd1) begin
              countdown_next   = '0;
              in_settings_next = 1'b0;
            end else begin
              countdown_next = countdown - 1'b1;
            end
          end
        end
        CMD_SET_MODE: begin
          if (nmode1 == MODE_CISTERN || nmode1 == MODE_MAINS || nmode1 == MODE_HYST) begin
            mode_next = nmode1;
          end
        end
        default: ;
      endcase
    end
  end

  // ring: oldest entry is prefetched into a register from the next write position
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[pos] <= smp1;
    end
    rd_data <= ring[pos_next];
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      cmd1   <= command;
      btn1   <= button_low;
      smp1   <= sample;
      nmode1 <= new_mode;
    end
    if (ready2 && v1) begin
      s2_flags <= '{mode: mode_next, settings: in_settings_next, tick: tick,
                    decide: tick && !in_settings_next};
      s2_sum   <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      s2_valid    <= 1'b0;
      mode        <= MODE_HYST;
      in_settings <= 1'b0;
      countdown   <= TIMEOUT_RST;
      since_press <= SINCE_PRESS_MAX;
      pos         <= '0;
      full        <= 1'b0;
      sum         <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (!item_stall) begin
        v1 <= item_valid;
      end
      if (ready2) begin
        s2_valid <= v1;
      end
      mode        <= mode_next;
      in_settings <= in_settings_next;
      countdown   <= countdown_next;
      since_press <= since_press_next;
      pos         <= pos_next;
      full        <= full_next;
      sum         <= sum_next;
      rd_valid    <= full_next;
    end
  end

  a_settings_close: assert property (@(posedge clk) disable iff (rst)
    adv && tick && in_settings && (countdown <= 8'd1) |=> !in_settings && (countdown == '0))
    else $error("settings mode did not close on countdown expiry");

  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    !ring_we |=> $stable(pos) && $stable(sum))
    else $error("window moved without a second tick");

endmodule

FILE: hw/rtl/tlvc_level.sv
// ----------------------------------------------------------------------------
// tlvc_level: level scaling products
// Multiplies the window sum by the liters and percent coefficients and
// registers both full-width products.
// ----------------------------------------------------------------------------
module tlvc_level import tlvc_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT,
  localparam int POS_W  = $clog2(WINDOW),
  localparam int SUM_W  = SAMPLE_W + POS_W,
  localparam int PROD_W = SUM_W + COEF_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s2_valid,
  input  beat_flags_t       s2_flags,
  input  logic [SUM_W-1:0]  s2_sum,
  input  logic [COEF_W-1:0] liters_per_count,
  input  logic [COEF_W-1:0] percent_per_count,
  output logic              ready_up,
  input  logic              down_ready,
  output logic              s3_valid,
  output beat_flags_t       s3_flags,
  output logic [SUM_W-1:0]  s3_sum,
  output logic [PROD_W-1:0] s3_liters_prod,
  output logic [PROD_W-1:0] s3_percent_prod
);

  assign ready_up = !s3_valid || down_ready;

  always_ff @(posedge clk) begin
    if (ready_up && s2_valid) begin
      s3_flags        <= s2_flags;
      s3_sum          <= s2_sum;
      s3_liters_prod  <= PROD_W'(s2_sum) * PROD_W'(liters_per_count);
      s3_percent_prod <= PROD_W'(s2_sum) * PROD_W'(percent_per_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (ready_up) begin
      s3_valid <= s2_valid;
    end
  end

endmodule

FILE: hw/rtl/tlvc_out.sv
// ----------------------------------------------------------------------------
// tlvc_out: level capping, valve decision and result register
// Caps liters and percent, runs the fixed modes and the auto hysteresis,
// and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module tlvc_out import tlvc_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT,
  localparam int POS_W  = $clog2(WINDOW),
  localparam int SUM_W  = SAMPLE_W + POS_W,
  localparam int PROD_W = SUM_W + COEF_W,
  localparam int LR_W   = PROD_W - POS_W - 8,
  localparam int PR_W   = PROD_W - POS_W - 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s3_valid,
  input  beat_flags_t          s3_flags,
  input  logic [SUM_W-1:0]     s3_sum,
  input  logic [PROD_W-1:0]    s3_liters_prod,
  input  logic [PROD_W-1:0]    s3_percent_prod,
  input  cfg_t                 cfg,
  output logic                 ready_up,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 valve_mains,
  output logic [REASON_W-1:0]  switch_reason,
  output logic [MODE_W-1:0]    current_mode,
  output logic                 settings_active,
  output logic [LITERS_W-1:0]  level_liters,
  output logic [PERCENT_W-1:0] level_percent,
  output logic [SAMPLE_W-1:0]  average_count
);

  logic [LR_W-1:0]      liters_raw;
  logic [PR_W-1:0]      percent_raw;
  logic [LITERS_W-1:0]  liters_cap, liters_new;
  logic [PERCENT_W-1:0] percent_cap;
  logic                 valve_next;
  logic [REASON_W-1:0]  reason_next;

  assign ready_up    = !result_valid || !result_stall;
  assign liters_raw  = s3_liters_prod[PROD_W-1:POS_W+8];
  assign percent_raw = s3_percent_prod[PROD_W-1:POS_W+16];
  assign liters_cap  = (liters_raw > LR_W'(cfg.full_liters)) ? cfg.full_liters
                                                              : liters_raw[LITERS_W-1:0];
  assign percent_cap = (percent_raw > PR_W'(PERCENT_MAX)) ? PERCENT_MAX
                                                         : percent_raw[PERCENT_W-1:0];
  assign liters_new  = s3_flags.tick ? liters_cap : level_liters;

  always_comb begin
    valve_next  = valve_mains;
    reason_next = switch_reason;
    if (s3_flags.decide) begin
      case (s3_flags.mode)
        MODE_CISTERN: begin
          valve_next  = 1'b0;
          reason_next = REASON_MANUAL;
        end
        MODE_MAINS: begin
          valve_next  = 1'b1;
          reason_next = REASON_MANUAL;
        end
        MODE_HYST: begin
          // low limit wins over high limit
          if (liters_new <= cfg.low_limit_liters) begin
            valve_next  = 1'b1;
            reason_next = REASON_EMPTY;
          end else if (liters_new >= cfg.high_limit_liters) begin
            valve_next  = 1'b0;
            reason_next = REASON_FULL;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid    <= 1'b0;
      valve_mains     <= 1'b0;
      switch_reason   <= REASON_MANUAL;
      current_mode    <= MODE_HYST;
      settings_active <= 1'b0;
      level_liters    <= '0;
      level_percent   <= '0;
      average_count   <= '0;
    end else if (ready_up) begin
      result_valid <= s3_valid;
      if (s3_valid) begin
        valve_mains     <= valve_next;
        switch_reason   <= reason_next;
        current_mode    <= s3_flags.mode;
        settings_active <= s3_flags.settings;
        average_count   <= s3_sum[SUM_W-1:POS_W];
        if (s3_flags.tick) begin
          level_liters  <= liters_cap;
          level_percent <= percent_cap;
        end
      end
    end
  end

  a_percent_cap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> level_percent <= PERCENT_MAX)
    else $error("level percent above cap");

  a_reason_valve: assert property (@(posedge clk) disable iff (rst)
    (switch_reason == REASON_FULL |-> !valve_mains) and
    (switch_reason == REASON_EMPTY |-> valve_mains))
    else $error("switch reason disagrees with valve");

endmodule

FILE: hw/rtl/tank_level_valve_controller.sv
// ----------------------------------------------------------------------------
// tank_level_valve_controller: tank level smoothing and valve control
// Takes one beat per cycle while item_stall is low and returns exactly one
// result beat per input beat, in order, through the four-register pipeline
// (input register, control and window update, coefficient multipliers,
// capping and valve decision into the result register); result_stall holds
// the result register and back-pressure reaches item_stall once all are full.
// Millisecond ticks debounce the mode button and run settings mode, second
// ticks push a sample into a moving-average window of WINDOW entries (a power
// of two), count settings mode down and decide the valve outside settings
// mode, set-mode beats write the mode if it is a valid code. The sample ring
// needs no clearing pass after reset. Configuration is to be written through
// cfg_write, cfg_index and cfg_data only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module tank_level_valve_controller import tlvc_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [CMD_W-1:0]       command,
  input  logic                   button_low,
  input  logic [SAMPLE_W-1:0]    sample,
  input  logic [MODE_W-1:0]      new_mode,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   valve_mains,
  output logic [REASON_W-1:0]    switch_reason,
  output logic [MODE_W-1:0]      current_mode,
  output logic                   settings_active,
  output logic [LITERS_W-1:0]    level_liters,
  output logic [PERCENT_W-1:0]   level_percent,
  output logic [SAMPLE_W-1:0]    average_count
);

  localparam int POS_W  = $clog2(WINDOW);
  localparam int SUM_W  = SAMPLE_W + POS_W;
  localparam int PROD_W = SUM_W + COEF_W;

  cfg_t               cfg;
  logic               s2_valid, s3_valid, level_ready, out_ready;
  beat_flags_t        s2_flags, s3_flags;
  logic [SUM_W-1:0]   s2_sum, s3_sum;
  logic [PROD_W-1:0]  s3_liters_prod, s3_percent_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_liters        <= FULL_LITERS_RST;
      cfg.liters_per_count   <= LITERS_PER_COUNT_RST;
      cfg.percent_per_count  <= PERCENT_PER_COUNT_RST;
      cfg.low_limit_liters   <= LOW_LIMIT_RST;
      cfg.high_limit_liters  <= HIGH_LIMIT_RST;
      cfg.settings_timeout_s <= TIMEOUT_RST;
      cfg.debounce_ms        <= DEBOUNCE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FULL_LITERS:       cfg.full_liters        <= cfg_data;
        CFG_LITERS_PER_COUNT:  cfg.liters_per_count   <= cfg_data;
        CFG_PERCENT_PER_COUNT: cfg.percent_per_count  <= cfg_data;
        CFG_LOW_LIMIT_LITERS:  cfg.low_limit_liters   <= cfg_data;
        CFG_HIGH_LIMIT_LITERS: cfg.high_limit_liters  <= cfg_data;
        CFG_SETTINGS_TIMEOUT:  cfg.settings_timeout_s <= cfg_data[TIMEOUT_W-1:0];
        CFG_DEBOUNCE_MS:       cfg.debounce_ms        <= cfg_data[DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  tlvc_ctrl #(.WINDOW(WINDOW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .command    (command),
    .button_low (button_low),
    .sample     (sample),
    .new_mode   (new_mode),
    .cfg        (cfg),
    .down_ready (level_ready),
    .s2_valid   (s2_valid),
    .s2_flags   (s2_flags),
    .s2_sum     (s2_sum)
  );

  tlvc_level #(.WINDOW(WINDOW)) u_level (
    .clk               (clk),
    .rst               (rst),
    .s2_valid          (s2_valid),
    .s2_flags          (s2_flags),
    .s2_sum            (s2_sum),
    .liters_per_count  (cfg.liters_per_count),
    .percent_per_count (cfg.percent_per_count),
    .ready_up          (level_ready),
    .down_ready        (out_ready),
    .s3_valid          (s3_valid),
    .s3_flags          (s3_flags),
    .s3_sum            (s3_sum),
    .s3_liters_prod    (s3_liters_prod),
    .s3_percent_prod   (s3_percent_prod)
  );

  tlvc_out #(.WINDOW(WINDOW)) u_out (
    .clk             (clk),
    .rst             (rst),
    .s3_valid        (s3_valid),
    .s3_flags        (s3_flags),
    .s3_sum          (s3_sum),
    .s3_liters_prod  (s3_liters_prod),
    .s3_percent_prod (s3_percent_prod),
    .cfg             (cfg),
    .ready_up        (out_ready),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .valve_mains     (valve_mains),
    .switch_reason   (switch_reason),
    .current_mode    (current_mode),
    .settings_active (settings_active),
    .level_liters    (level_liters),
    .level_percent   (level_percent),
    .average_count   (average_count)
  );

endmodule
